// ===== hw/rtl/oscillator_adsr_voice_core_macros.svh =====
// Assertion macros shared by the voice RTL files.
`ifndef OSCILLATOR_ADSR_VOICE_CORE_MACROS_SVH
`define OSCILLATOR_ADSR_VOICE_CORE_MACROS_SVH
`ifndef SYNTH
// Check prop at every rising clock edge outside reset.
`define OSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check prop at every rising clock edge, reset included.
`define OSC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OSC_ASSERT(label, clk, rst, prop, msg)
`define OSC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/osc_adsr_pkg.sv =====
// Types, constants and the quarter-wave sine table of the voice.
package osc_adsr_pkg;

   localparam int PHASE_BITS      = 24;
   localparam int LEVEL_FRAC_BITS = 24;
   localparam int SINE_ADDR_BITS  = 8;

   localparam int LEVEL_W     = LEVEL_FRAC_BITS + 1;
   localparam int SAMPLE_W    = 16;
   localparam int SINE_W      = 15;
   localparam int SINE_DEPTH  = 1 << SINE_ADDR_BITS;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = LEVEL_W;

   localparam logic [LEVEL_W-1:0] LEVEL_ONE  = LEVEL_W'(1) << LEVEL_FRAC_BITS;
   localparam logic [LEVEL_W-1:0] LEVEL_HALF = LEVEL_W'(1) << (LEVEL_FRAC_BITS - 1);

   // input word kinds
   localparam logic [1:0] KIND_TICK     = 2'd0;
   localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
   localparam logic [1:0] KIND_NOTE_OFF = 2'd2;

   // envelope stages
   localparam logic [2:0] STAGE_IDLE    = 3'd0;
   localparam logic [2:0] STAGE_ATTACK  = 3'd1;
   localparam logic [2:0] STAGE_DECAY   = 3'd2;
   localparam logic [2:0] STAGE_SUSTAIN = 3'd3;
   localparam logic [2:0] STAGE_RELEASE = 3'd4;

   // waveforms
   localparam logic [1:0] WAVE_SINE     = 2'd0;
   localparam logic [1:0] WAVE_SQUARE   = 2'd1;
   localparam logic [1:0] WAVE_SAW      = 2'd2;
   localparam logic [1:0] WAVE_TRIANGLE = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WAVEFORM     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK_STEP  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_STEP   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_LEVEL   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_STEP = 3'd4;

   // register reset values
   localparam logic [1:0]         RESET_WAVEFORM     = WAVE_SINE;
   localparam logic [LEVEL_W-1:0] RESET_ATTACK_STEP  = LEVEL_W'(38043);
   localparam logic [LEVEL_W-1:0] RESET_DECAY_STEP   = LEVEL_W'(1141);
   localparam logic [LEVEL_W-1:0] RESET_HOLD_LEVEL   = LEVEL_W'(11744051);
   localparam logic [LEVEL_W-1:0] RESET_RELEASE_STEP = LEVEL_W'(1332);

   typedef struct packed {
      logic [1:0]            kind;
      logic [PHASE_BITS-1:0] phase_step;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [2:0]                 env_stage;
      logic                       voice_active;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]         waveform;
      logic [LEVEL_W-1:0] attack_step;
      logic [LEVEL_W-1:0] decay_step;
      logic [LEVEL_W-1:0] hold_level;
      logic [LEVEL_W-1:0] release_step;
   } cfg_type;

   typedef struct packed {
      logic note_on;
      logic note_off;
      logic tick;
   } env_ctrl_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [2:0]         stage;
      logic               active;
   } env_state_type;

   typedef logic [SINE_W-1:0] sine_rom_type [0:SINE_DEPTH-1];

   localparam longint unsigned Q30_ONE     = 64'd1 << 30;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Q30 Taylor sine through x^11, Horner form with truncating shifts.
   function automatic logic [SINE_W-1:0] sine_entry(input longint unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned v;
      x  = (k * HALF_PI_Q30) >> SINE_ADDR_BITS;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[SINE_W-1:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int k = 0; k < SINE_DEPTH; k++) begin
         rom[k] = sine_entry(longint'(k));
      end
      return rom;
   endfunction

   localparam sine_rom_type      SINE_ROM  = build_sine_rom();
   // entry at a full quarter, read only at the quarter boundaries
   localparam logic [SINE_W-1:0] SINE_PEAK = sine_entry(longint'(SINE_DEPTH));

endpackage

// ===== hw/rtl/osc_adsr_csr.sv =====
// Configuration registers of the voice.
module osc_adsr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [osc_adsr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [osc_adsr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output osc_adsr_pkg::cfg_type                cfg
);

   osc_adsr_pkg::cfg_type cfg_ff;
   osc_adsr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            osc_adsr_pkg::CSR_WAVEFORM:     cfg_in.waveform     = csr_wdata[1:0];
            osc_adsr_pkg::CSR_ATTACK_STEP:  cfg_in.attack_step  = csr_wdata;
            osc_adsr_pkg::CSR_DECAY_STEP:   cfg_in.decay_step   = csr_wdata;
            osc_adsr_pkg::CSR_HOLD_LEVEL:   cfg_in.hold_level   = csr_wdata;
            osc_adsr_pkg::CSR_RELEASE_STEP: cfg_in.release_step = csr_wdata;
            default:                        cfg_in = cfg_ff;  // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.waveform     <= osc_adsr_pkg::RESET_WAVEFORM;
         cfg_ff.attack_step  <= osc_adsr_pkg::RESET_ATTACK_STEP;
         cfg_ff.decay_step   <= osc_adsr_pkg::RESET_DECAY_STEP;
         cfg_ff.hold_level   <= osc_adsr_pkg::RESET_HOLD_LEVEL;
         cfg_ff.release_step <= osc_adsr_pkg::RESET_RELEASE_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/osc_adsr_wave.sv =====
// Waveform generator: sine, square, sawtooth and triangle from the phase.
module osc_adsr_wave (
   input  logic [1:0]                             waveform,
   input  logic [osc_adsr_pkg::PHASE_BITS-1:0]    phase,
   output logic signed [osc_adsr_pkg::SAMPLE_W-1:0] wave
);

   localparam int SAB = osc_adsr_pkg::SINE_ADDR_BITS;
   localparam int PB  = osc_adsr_pkg::PHASE_BITS;

   logic [15:0]                u;
   logic [1:0]                 quad;
   logic [SAB-1:0]             addr;
   logic [SAB:0]               sine_idx;
   logic [osc_adsr_pkg::SINE_W-1:0] sine_mag;
   logic signed [15:0]         sine_v;
   logic signed [17:0]         tri_raw;
   logic signed [15:0]         tri_v;

   assign u    = phase[PB-1 -: 16];
   assign quad = phase[PB-1 -: 2];
   assign addr = phase[PB-3 -: SAB];

   // mirror the index on odd quarters
   assign sine_idx = quad[0] ? ({1'b1, {SAB{1'b0}}} - {1'b0, addr}) : {1'b0, addr};

   always_comb begin
      if (sine_idx[SAB]) begin
         sine_mag = osc_adsr_pkg::SINE_PEAK;
      end else begin
         sine_mag = osc_adsr_pkg::SINE_ROM[sine_idx[SAB-1:0]];
      end
   end

   assign sine_v = quad[1] ? (16'sd0 - $signed({1'b0, sine_mag}))
                           : $signed({1'b0, sine_mag});

   // rise over the first half, fall over the second; clip the single overshoot
   assign tri_raw = u[15] ? (18'sd98304 - $signed({1'b0, u, 1'b0}))
                          : ($signed({1'b0, u, 1'b0}) - 18'sd32768);
   assign tri_v   = (tri_raw > 18'sd32767) ? 16'sd32767 : tri_raw[15:0];

   always_comb begin
      case (waveform)
         osc_adsr_pkg::WAVE_SINE:     wave = sine_v;
         osc_adsr_pkg::WAVE_SQUARE:   wave = u[15] ? -16'sd32767 : 16'sd32767;
         osc_adsr_pkg::WAVE_SAW:      wave = $signed({~u[15], u[14:0]});
         osc_adsr_pkg::WAVE_TRIANGLE: wave = tri_v;
         default:                     wave = sine_v;
      endcase
   end

endmodule

// ===== hw/rtl/osc_adsr_env.sv =====
// Linear ADSR envelope: level, stage and voice active flag.
`include "oscillator_adsr_voice_core_macros.svh"
module osc_adsr_env (
   input  logic                        clock,
   input  logic                        reset,
   input  osc_adsr_pkg::cfg_type       cfg,
   input  osc_adsr_pkg::env_ctrl_type  ctrl,
   output osc_adsr_pkg::env_state_type env_cur,
   output osc_adsr_pkg::env_state_type env_next
);

   localparam int LW = osc_adsr_pkg::LEVEL_W;

   osc_adsr_pkg::env_state_type env_ff;
   osc_adsr_pkg::env_state_type env_in;
   osc_adsr_pkg::env_state_type stepped;

   logic [LW-1:0] sus_eff;
   logic [LW:0]   attack_sum;
   logic [LW-1:0] decay_gap;

   assign sus_eff    = (cfg.hold_level > osc_adsr_pkg::LEVEL_ONE) ?
                       osc_adsr_pkg::LEVEL_ONE : cfg.hold_level;
   assign attack_sum = {1'b0, env_ff.level} + {1'b0, cfg.attack_step};
   assign decay_gap  = env_ff.level - sus_eff;

   // one sample of envelope advance
   always_comb begin
      stepped = env_ff;
      case (env_ff.stage)
         osc_adsr_pkg::STAGE_ATTACK: begin
            if (attack_sum >= {1'b0, osc_adsr_pkg::LEVEL_ONE}) begin
               stepped.level = osc_adsr_pkg::LEVEL_ONE;
               stepped.stage = osc_adsr_pkg::STAGE_DECAY;
            end else begin
               stepped.level = attack_sum[LW-1:0];
            end
         end
         osc_adsr_pkg::STAGE_DECAY: begin
            if (env_ff.level > sus_eff && decay_gap > cfg.decay_step) begin
               stepped.level = env_ff.level - cfg.decay_step;
            end else begin
               stepped.level = sus_eff;
               stepped.stage = osc_adsr_pkg::STAGE_SUSTAIN;
            end
         end
         osc_adsr_pkg::STAGE_SUSTAIN: begin
            stepped.level = sus_eff;
         end
         osc_adsr_pkg::STAGE_RELEASE: begin
            if (env_ff.level > cfg.release_step) begin
               stepped.level = env_ff.level - cfg.release_step;
            end else begin
               stepped.level = '0;
               stepped.stage = osc_adsr_pkg::STAGE_IDLE;
            end
         end
         default: begin
            stepped.level = '0;
            stepped.stage = osc_adsr_pkg::STAGE_IDLE;
         end
      endcase
      stepped.active = (stepped.stage != osc_adsr_pkg::STAGE_IDLE);
   end

   always_comb begin
      env_in = env_ff;
      if (ctrl.note_on) begin
         env_in.level  = '0;
         env_in.stage  = osc_adsr_pkg::STAGE_ATTACK;
         env_in.active = 1'b1;
      end else if (ctrl.note_off) begin
         env_in.level = sus_eff;
         env_in.stage = osc_adsr_pkg::STAGE_RELEASE;
      end else if (ctrl.tick && env_ff.active) begin
         env_in = stepped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff.level  <= '0;
         env_ff.stage  <= osc_adsr_pkg::STAGE_IDLE;
         env_ff.active <= 1'b0;
      end else begin
         env_ff <= env_in;
      end
   end

   assign env_cur  = env_ff;
   assign env_next = env_in;

   `OSC_ASSERT(a_level_max, clock, reset, env_ff.level <= osc_adsr_pkg::LEVEL_ONE, "envelope level above one")
   `OSC_ASSERT(a_note_on_restart, clock, reset, ctrl.note_on |=> (env_ff.stage == osc_adsr_pkg::STAGE_ATTACK && env_ff.level == '0 && env_ff.active), "note on did not restart attack")
   `OSC_ASSERT(a_sustain_hold, clock, reset, (env_ff.active && env_ff.stage == osc_adsr_pkg::STAGE_SUSTAIN && ctrl.tick && !ctrl.note_on && !ctrl.note_off) |=> env_ff.level == $past(sus_eff), "sustain level not held")

endmodule

// ===== hw/rtl/oscillator_adsr_voice_core.sv =====
// Top level of the single synth voice: input and result registers, phase and scaling.
//
// Usage
//   req channel: one word per item, kind 0 sample tick, 1 note on (takes
//   phase_step), 2 note off; kind 3 is dropped. Only a tick gives a result.
//   rsp channel: one word per tick with the scaled sample, the envelope
//   stage after the step and the voice active flag.
//   csr channel: register writes by index (0 waveform, 1 attack step,
//   2 decay step, 3 sustain level, 4 release step); csr_ready is always
//   high, and an unknown index is dropped. Write only while the voice idles.
// Timing
//   A tick word passes through the input register and then the result
//   register before it shows on rsp. The envelope step, table read and
//   the 16x25 scaling multiply lie between those two registers, so one
//   word is taken every cycle unless a tick waits on a stalled rsp.
// Reset clears state and loads register defaults; no clearing pass.
// A stalled rsp holds its word; the input register still drains note on
// and note off words, and a tick waits until the result register frees.
`include "oscillator_adsr_voice_core_macros.svh"
module oscillator_adsr_voice_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  osc_adsr_pkg::req_word_type           req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output osc_adsr_pkg::rsp_word_type           rsp_word,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [osc_adsr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [osc_adsr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PB     = osc_adsr_pkg::PHASE_BITS;
   localparam int LW     = osc_adsr_pkg::LEVEL_W;
   localparam int SW     = osc_adsr_pkg::SAMPLE_W;
   localparam int PROD_W = SW + LW;

   osc_adsr_pkg::cfg_type       cfg;
   osc_adsr_pkg::env_ctrl_type  env_ctrl;
   osc_adsr_pkg::env_state_type env_cur;
   osc_adsr_pkg::env_state_type env_next;

   logic                        in_valid_ff;
   logic                        in_valid_in;
   osc_adsr_pkg::req_word_type  in_word_ff;
   osc_adsr_pkg::req_word_type  in_word_in;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   osc_adsr_pkg::rsp_word_type  out_word_ff;
   osc_adsr_pkg::rsp_word_type  out_word_in;
   logic [PB-1:0]               phase_accum_ff;
   logic [PB-1:0]               phase_accum_in;
   logic [PB-1:0]               phase_incr_ff;
   logic [PB-1:0]               phase_incr_in;

   logic                        is_tick;
   logic                        advance;
   logic                        tick_live;
   logic signed [SW-1:0]        wave;
   logic [SW-1:0]               mag;
   logic [PROD_W-1:0]           prod;
   logic [PROD_W:0]             rounded;
   logic [SW-1:0]               scaled;

   // configuration, always ready
   assign csr_ready = 1'b1;

   osc_adsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // advance the input word unless it is a tick facing a full, stalled result
   assign is_tick   = (in_word_ff.kind == osc_adsr_pkg::KIND_TICK);
   assign advance   = in_valid_ff && (!is_tick || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   assign env_ctrl.note_on  = advance && (in_word_ff.kind == osc_adsr_pkg::KIND_NOTE_ON);
   assign env_ctrl.note_off = advance && (in_word_ff.kind == osc_adsr_pkg::KIND_NOTE_OFF);
   assign env_ctrl.tick     = advance && is_tick;

   osc_adsr_env u_env (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .ctrl     (env_ctrl),
      .env_cur  (env_cur),
      .env_next (env_next)
   );

   // a tick of a silent voice leaves phase and envelope alone
   assign tick_live = env_ctrl.tick && env_cur.active;

   always_comb begin
      phase_incr_in  = phase_incr_ff;
      phase_accum_in = phase_accum_ff;
      if (env_ctrl.note_on) begin
         phase_incr_in = in_word_ff.phase_step;
      end
      if (tick_live) begin
         phase_accum_in = phase_accum_ff + phase_incr_ff;
      end
   end

   osc_adsr_wave u_wave (
      .waveform (cfg.waveform),
      .phase    (phase_accum_ff),
      .wave     (wave)
   );

   // scale the magnitude by the stepped level with rounding, then restore the sign
   assign mag     = !env_cur.active ? '0 :
                    (wave[SW-1] ? (SW'(0) - wave) : wave);
   assign prod    = PROD_W'(mag) * PROD_W'(env_next.level);
   assign rounded = {1'b0, prod} + (PROD_W + 1)'(osc_adsr_pkg::LEVEL_HALF);
   assign scaled  = rounded[osc_adsr_pkg::LEVEL_FRAC_BITS +: SW];

   always_comb begin
      out_word_in              = out_word_ff;
      out_valid_in             = out_valid_ff;
      if (env_ctrl.tick) begin
         out_word_in.sample       = wave[SW-1] ? $signed(SW'(0) - scaled) : $signed(scaled);
         out_word_in.env_stage    = env_next.stage;
         out_word_in.voice_active = env_next.active;
         out_valid_in             = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         phase_accum_ff <= '0;
         phase_incr_ff  <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         phase_accum_ff <= phase_accum_in;
         phase_incr_ff  <= phase_incr_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   `OSC_ASSERT(a_silent_word, clock, reset, (rsp_valid && !rsp_word.voice_active) |-> rsp_word.sample == '0, "inactive voice gave a nonzero sample")
   `OSC_ASSERT(a_idle_inactive, clock, reset, (rsp_valid && rsp_word.voice_active) |-> rsp_word.env_stage != osc_adsr_pkg::STAGE_IDLE, "active voice reports idle stage")
   `OSC_ASSERT(a_phase_frozen, clock, reset, (!env_cur.active && !env_ctrl.note_on) |=> $stable(phase_accum_ff), "phase moved while the voice was silent")

endmodule
